>>> rtl/sip_pkg.sv
// sip_pkg: shared types, codes and default sizes for the string intern pool.
// Used by every module under rtl/ except sip_ram.
package sip_pkg;

	localparam int PAGE_SIZE_DEF   = 1024;
	localparam int PAGE_COUNT_DEF  = 4;
	localparam int MAX_ENTRIES_DEF = 64;

	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 10;
	localparam int OFF_W      = 12;
	localparam int ADDR_W     = 12;
	localparam int PEND_DEPTH = 1024;
	localparam int PEND_AW    = 10;
	localparam int FIFO_DEPTH = 2;

	localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

	localparam logic [1:0] OP_CHAR  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] CMD_END   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic KIND_INTERN = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

endpackage

>>> rtl/sip_ram.sv
// sip_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sip_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/sip_cmd_fifo.sv
// sip_cmd_fifo: short command queue between front and back.
// Depends on sip_pkg.
module sip_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sip_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output sip_pkg::cmd_t pop_cmd
);

	localparam int PW = $clog2(sip_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(sip_pkg::FIFO_DEPTH + 1);

	sip_pkg::cmd_t mem_q [sip_pkg::FIFO_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(sip_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_cmd   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(sip_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(sip_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/sip_front.sv
// sip_front: accepts items, gathers string characters into the pending buffer
// and queues end, read and clear commands. Depends on sip_pkg.
module sip_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic [sip_pkg::CHAR_W-1:0]          char_value,
	input  logic                                last_char,
	input  logic                                end_only,
	input  logic [sip_pkg::ADDR_W-1:0]          read_address,
	output logic                                pw_en,
	output logic [sip_pkg::PEND_AW-1:0]         pw_addr,
	output logic [sip_pkg::CHAR_W-1:0]          pw_data,
	output logic                                push,
	output sip_pkg::cmd_t                       push_cmd,
	input  logic                                fifo_full,
	input  logic                                str_done
);

	logic [sip_pkg::LEN_W-1:0] plen_q;
	logic                      busy_q;
	logic                      acc, add;

	assign in_ready = !fifo_full && !busy_q;
	assign acc      = in_valid && in_ready;
	assign add      = !(last_char && end_only) && (plen_q < sip_pkg::LEN_MAX);

	assign pw_en   = acc && (op == sip_pkg::OP_CHAR) && add;
	assign pw_addr = plen_q;
	assign pw_data = char_value;

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = sip_pkg::CMD_END;
		push_cmd.len  = plen_q + sip_pkg::LEN_W'(add);
		push_cmd.addr = read_address;
		if (acc) begin
			case (op)
				sip_pkg::OP_CHAR: begin
					push = last_char;
				end
				sip_pkg::OP_READ: begin
					push          = 1'b1;
					push_cmd.kind = sip_pkg::CMD_READ;
				end
				sip_pkg::OP_CLEAR: begin
					push          = 1'b1;
					push_cmd.kind = sip_pkg::CMD_CLEAR;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (str_done) begin
				busy_q <= 1'b0;
			end
			if (acc && op == sip_pkg::OP_CHAR) begin
				if (last_char) begin
					plen_q <= '0;
					busy_q <= 1'b1;
				end else if (add) begin
					plen_q <= plen_q + 1'b1;
				end
			end else if (acc && op == sip_pkg::OP_CLEAR) begin
				plen_q <= '0;
			end
		end
	end

endmodule

>>> rtl/sip_back.sv
// sip_back: runs queued commands: entry search, page allocation, copy into
// the character store, reads, clear; holds the result register. Depends on
// sip_pkg and sip_ram.
module sip_back #(
	parameter int PAGE_SIZE   = sip_pkg::PAGE_SIZE_DEF,
	parameter int PAGE_COUNT  = sip_pkg::PAGE_COUNT_DEF,
	parameter int MAX_ENTRIES = sip_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  sip_pkg::cmd_t                cmd,
	output logic                         pop,
	output logic [sip_pkg::PEND_AW-1:0]  pd_raddr,
	input  logic [sip_pkg::CHAR_W-1:0]   pd_rdata,
	output logic                         str_done,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sip_pkg::OFF_W-1:0]    entry_offset,
	output logic [sip_pkg::LEN_W-1:0]    entry_length,
	output logic                         found_existing,
	output logic                         pool_full,
	output logic [sip_pkg::CHAR_W-1:0]   read_data,
	output logic                         result_kind
);

	localparam int STORE_SIZE = PAGE_SIZE * PAGE_COUNT;
	localparam int SAW  = $clog2(STORE_SIZE);
	localparam int EW   = $clog2(MAX_ENTRIES);
	localparam int CNTW = $clog2(MAX_ENTRIES + 1);
	localparam int PGW  = $clog2(PAGE_COUNT + 2);
	localparam int POW  = $clog2(PAGE_SIZE + 1);
	localparam int NW   = sip_pkg::LEN_W + 1;
	localparam int CMPW = (POW > NW) ? POW + 1 : NW + 1;
	localparam int EDW  = SAW + sip_pkg::LEN_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ENT_RD  = 4'd1;
	localparam logic [3:0] ST_ENT_CHK = 4'd2;
	localparam logic [3:0] ST_CMP_RD  = 4'd3;
	localparam logic [3:0] ST_CMP_CHK = 4'd4;
	localparam logic [3:0] ST_ALLOC   = 4'd5;
	localparam logic [3:0] ST_COPY_RD = 4'd6;
	localparam logic [3:0] ST_COPY_WR = 4'd7;
	localparam logic [3:0] ST_TERM    = 4'd8;
	localparam logic [3:0] ST_RD_A    = 4'd9;
	localparam logic [3:0] ST_RD_D    = 4'd10;
	localparam logic [3:0] ST_OUT     = 4'd11;

	logic [3:0]                 state_q;
	logic [sip_pkg::LEN_W-1:0]  len_q, k_q;
	logic [SAW-1:0]             addr_q, off_q, ent_off_q;
	logic [EW-1:0]              idx_q;
	logic [CNTW-1:0]            cnt_q;
	logic [PGW-1:0]             page_q;
	logic [POW-1:0]             poff_q;

	logic [sip_pkg::OFF_W-1:0]  res_off_q;
	logic [sip_pkg::LEN_W-1:0]  res_len_q;
	logic                       res_found_q, res_full_q, res_kind_q;
	logic [sip_pkg::CHAR_W-1:0] res_data_q;
	logic                       ov_q;

	logic                       cs_we;
	logic [SAW-1:0]             cs_waddr, cs_raddr;
	logic [sip_pkg::CHAR_W-1:0] cs_wdata, cs_rdata;
	logic                       en_we;
	logic [EDW-1:0]             en_wdata, en_rdata;
	logic [SAW-1:0]             en_roff;
	logic [sip_pkg::LEN_W-1:0]  en_rlen;

	logic [NW-1:0]              need;
	logic                       brk, full_c;
	logic [PGW-1:0]             pg;
	logic [POW-1:0]             po;
	logic [CMPW-1:0]            npo;
	logic                       last_ent, load;

	assign en_roff = en_rdata[EDW-1:sip_pkg::LEN_W];
	assign en_rlen = en_rdata[sip_pkg::LEN_W-1:0];

	sip_ram #(.WIDTH(sip_pkg::CHAR_W), .DEPTH(STORE_SIZE)) u_char_store (
		.clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
		.raddr(cs_raddr), .rdata(cs_rdata)
	);

	sip_ram #(.WIDTH(EDW), .DEPTH(MAX_ENTRIES)) u_entries (
		.clk(clk), .we(en_we), .waddr(cnt_q[EW-1:0]), .wdata(en_wdata),
		.raddr(idx_q), .rdata(en_rdata)
	);

	assign pd_raddr = k_q;
	assign cs_raddr = (state_q == ST_CMP_RD) ? ent_off_q + SAW'(k_q) : addr_q;
	assign cs_we    = (state_q == ST_COPY_WR) || (state_q == ST_TERM);
	assign cs_waddr = off_q + SAW'((state_q == ST_TERM) ? len_q : k_q);
	assign cs_wdata = (state_q == ST_TERM) ? '0 : pd_rdata;
	assign en_we    = (state_q == ST_TERM);
	assign en_wdata = {off_q, len_q};

	assign need   = NW'(len_q) + 1'b1;
	assign brk    = CMPW'(need) > CMPW'(PAGE_SIZE) - CMPW'(poff_q);
	assign pg     = page_q + PGW'(brk);
	assign po     = brk ? '0 : poff_q;
	assign npo    = CMPW'(po) + CMPW'(need);
	assign full_c = (CMPW'(need) > CMPW'(PAGE_SIZE)) || (32'(pg) >= PAGE_COUNT)
		|| (32'(cnt_q) >= MAX_ENTRIES);

	assign last_ent = (CNTW'(idx_q) + 1'b1 == cnt_q);
	assign pop      = (state_q == ST_IDLE) && cmd_valid;
	assign load     = (state_q == ST_OUT) && (!ov_q || out_ready);
	assign str_done = load && (res_kind_q == sip_pkg::KIND_INTERN);

	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			page_q  <= '0;
			poff_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							sip_pkg::CMD_END: begin
								state_q <= (cnt_q == '0) ? ST_ALLOC : ST_ENT_RD;
							end
							sip_pkg::CMD_READ: begin
								state_q <= (32'(cmd.addr) < STORE_SIZE) ? ST_RD_A : ST_OUT;
							end
							sip_pkg::CMD_CLEAR: begin
								cnt_q  <= '0;
								page_q <= '0;
								poff_q <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ENT_RD: state_q <= ST_ENT_CHK;
				ST_ENT_CHK: begin
					if (en_rlen == len_q) begin
						state_q <= (len_q == '0) ? ST_OUT : ST_CMP_RD;
					end else begin
						state_q <= last_ent ? ST_ALLOC : ST_ENT_RD;
					end
				end
				ST_CMP_RD: state_q <= ST_CMP_CHK;
				ST_CMP_CHK: begin
					if (cs_rdata != pd_rdata) begin
						state_q <= last_ent ? ST_ALLOC : ST_ENT_RD;
					end else if (k_q + 1'b1 == len_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CMP_RD;
					end
				end
				ST_ALLOC: begin
					if (full_c) begin
						state_q <= ST_OUT;
					end else begin
						if (npo == CMPW'(PAGE_SIZE)) begin
							page_q <= pg + 1'b1;
							poff_q <= '0;
						end else begin
							page_q <= pg;
							poff_q <= POW'(npo);
						end
						state_q <= (len_q == '0) ? ST_TERM : ST_COPY_RD;
					end
				end
				ST_COPY_RD: state_q <= ST_COPY_WR;
				ST_COPY_WR: state_q <= (k_q + 1'b1 == len_q) ? ST_TERM : ST_COPY_RD;
				ST_TERM: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= ST_OUT;
				end
				ST_RD_A: state_q <= ST_RD_D;
				ST_RD_D: state_q <= ST_OUT;
				ST_OUT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				len_q       <= cmd.len;
				addr_q      <= SAW'(cmd.addr);
				idx_q       <= '0;
				k_q         <= '0;
				res_off_q   <= '0;
				res_len_q   <= '0;
				res_found_q <= 1'b0;
				res_full_q  <= 1'b0;
				res_data_q  <= '0;
				res_kind_q  <= (cmd.kind == sip_pkg::CMD_READ) ? sip_pkg::KIND_READ
					: sip_pkg::KIND_INTERN;
			end
			ST_ENT_CHK: begin
				ent_off_q <= en_roff;
				k_q       <= '0;
				if (en_rlen == len_q && len_q == '0) begin
					res_off_q   <= sip_pkg::OFF_W'(en_roff);
					res_len_q   <= en_rlen;
					res_found_q <= 1'b1;
				end else if (en_rlen != len_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_CMP_CHK: begin
				if (cs_rdata != pd_rdata) begin
					idx_q <= idx_q + 1'b1;
				end else if (k_q + 1'b1 == len_q) begin
					res_off_q   <= sip_pkg::OFF_W'(ent_off_q);
					res_len_q   <= len_q;
					res_found_q <= 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_ALLOC: begin
				k_q       <= '0;
				off_q     <= SAW'(pg) * SAW'(PAGE_SIZE) + SAW'(po);
				res_len_q <= len_q;
				res_full_q <= full_c;
			end
			ST_COPY_WR: k_q <= k_q + 1'b1;
			ST_TERM: res_off_q <= sip_pkg::OFF_W'(off_q);
			ST_RD_D: res_data_q <= cs_rdata;
			default: begin
				res_kind_q <= res_kind_q;
			end
		endcase
		if (load) begin
			entry_offset   <= res_off_q;
			entry_length   <= res_len_q;
			found_existing <= res_found_q;
			pool_full      <= res_full_q;
			read_data      <= res_data_q;
			result_kind    <= res_kind_q;
		end
	end

endmodule

>>> rtl/string_intern_pool_top.sv
// string_intern_pool_top: string interning table, front/queue/back split.
// Depends on sip_pkg, sip_ram, sip_front, sip_cmd_fifo, sip_back.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | op, char_value, last_char, end_only, read_address
//   out     | out_valid/ out_ready | entry_offset, entry_length, found_existing,
//           |                      | pool_full, read_data, result_kind
//
// Characters are taken one per cycle while the queue has room and no string
// end is pending. A string end searches entries one at a time, comparing them
// character by character, then copies an unmatched string into the store; input
// stalls until that result is loaded. Reset clears counters and state only; no sweep.
module string_intern_pool_top #(
	parameter int PAGE_SIZE   = sip_pkg::PAGE_SIZE_DEF,
	parameter int PAGE_COUNT  = sip_pkg::PAGE_COUNT_DEF,
	parameter int MAX_ENTRIES = sip_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [sip_pkg::CHAR_W-1:0]  char_value,
	input  logic                        last_char,
	input  logic                        end_only,
	input  logic [sip_pkg::ADDR_W-1:0]  read_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sip_pkg::OFF_W-1:0]   entry_offset,
	output logic [sip_pkg::LEN_W-1:0]   entry_length,
	output logic                        found_existing,
	output logic                        pool_full,
	output logic [sip_pkg::CHAR_W-1:0]  read_data,
	output logic                        result_kind
);

	logic                         pw_en, push, fifo_full, pop, not_empty, str_done;
	logic [sip_pkg::PEND_AW-1:0]  pw_addr, pd_raddr;
	logic [sip_pkg::CHAR_W-1:0]   pw_data, pd_rdata;
	sip_pkg::cmd_t                push_cmd, pop_cmd;

	sip_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .char_value(char_value), .last_char(last_char), .end_only(end_only),
		.read_address(read_address), .pw_en(pw_en), .pw_addr(pw_addr), .pw_data(pw_data),
		.push(push), .push_cmd(push_cmd), .fifo_full(fifo_full), .str_done(str_done)
	);

	sip_ram #(.WIDTH(sip_pkg::CHAR_W), .DEPTH(sip_pkg::PEND_DEPTH)) u_pending (
		.clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
		.raddr(pd_raddr), .rdata(pd_rdata)
	);

	sip_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .full(fifo_full),
		.pop(pop), .not_empty(not_empty), .pop_cmd(pop_cmd)
	);

	sip_back #(
		.PAGE_SIZE(PAGE_SIZE), .PAGE_COUNT(PAGE_COUNT), .MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(not_empty), .cmd(pop_cmd), .pop(pop),
		.pd_raddr(pd_raddr), .pd_rdata(pd_rdata), .str_done(str_done),
		.out_valid(out_valid), .out_ready(out_ready), .entry_offset(entry_offset),
		.entry_length(entry_length), .found_existing(found_existing),
		.pool_full(pool_full), .read_data(read_data), .result_kind(result_kind)
	);

endmodule

>>> rtl/sip_checker.sv
// sip_checker: port-level assertions for string_intern_pool_top, with bind.
// Depends on sip_pkg.
module sip_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [sip_pkg::OFF_W-1:0]   entry_offset,
	input logic [sip_pkg::LEN_W-1:0]   entry_length,
	input logic                        found_existing,
	input logic                        pool_full,
	input logic [sip_pkg::CHAR_W-1:0]  read_data,
	input logic                        result_kind
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_offset)
			&& $stable(entry_length) && $stable(read_data) && $stable(result_kind))
		else $error("result changed while stalled");

	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == sip_pkg::KIND_READ |-> entry_offset == '0
			&& entry_length == '0 && !found_existing && !pool_full)
		else $error("read result carries intern fields");

	a_intern_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == sip_pkg::KIND_INTERN |-> read_data == '0)
		else $error("intern result carries read data");

	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found_existing && pool_full))
		else $error("found and full together");

	a_full_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pool_full |-> entry_offset == '0)
		else $error("full result with nonzero offset");

endmodule

bind string_intern_pool_top sip_checker u_sip_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.entry_offset(entry_offset), .entry_length(entry_length),
	.found_existing(found_existing), .pool_full(pool_full),
	.read_data(read_data), .result_kind(result_kind)
);
